// ----- src/rlf_pkg.sv -----
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared constants, function codes and sequencer states for the backward
// register liveness and free-run finder.
// ----------------------------------------------------------------------------
package rlf_pkg;

	// register file and table geometry
	localparam int NUM_VREGS  = 512;
	localparam int NUM_SLOTS  = 256;
	localparam int WORD_BITS  = 64;
	localparam int BIT_AW     = $clog2(WORD_BITS);
	localparam int WORDS      = NUM_VREGS / WORD_BITS;
	localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SLOT_AW    = $clog2(NUM_SLOTS);
	localparam int MEM_AW     = SLOT_AW + WORD_AW;
	localparam int MEM_DEPTH  = NUM_SLOTS * WORDS;

	// scan granule: bits examined per cycle during a free-run search
	localparam int STEP_BITS  = 8;
	localparam int STEP_AW    = $clog2(STEP_BITS);
	localparam int STEPS_AW   = BIT_AW - STEP_AW;

	// wide enough for base + count
	localparam int POS_W      = 11;

	// scalar register limits
	localparam int SCALAR_LAST  = 105;
	localparam int SCALAR_LIMIT = 106;

	// item function codes
	typedef enum logic [2:0] {
		FN_CLEAR   = 3'd0,
		FN_DST     = 3'd1,
		FN_SRC     = 3'd2,
		FN_END     = 3'd3,
		FN_FREERUN = 3'd4,
		FN_ISLIVE  = 3'd5,
		FN_SCALAR  = 3'd6,
		FN_PAIR    = 3'd7
	} func_t;

	// sequencer states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MARK = 8'b0000_0010,
		ST_SAVE = 8'b0000_0100,
		ST_RD   = 8'b0000_1000,
		ST_SCAN = 8'b0001_0000,
		ST_LIVE = 8'b0010_0000,
		ST_DONE = 8'b0100_0000,
		ST_SPARE = 8'b1000_0000
	} state_t;

endpackage

// ----- src/register_liveness_free_run_finder_core.sv -----
// ----------------------------------------------------------------------------
// register_liveness_free_run_finder_core
// Backward liveness over one basic block with saved per-slot live sets,
// first-fit free vector run search and free scalar register search.
// ----------------------------------------------------------------------------
// Flow: clear, scalar ops and non-vector operands go straight to the result;
//   vector range marking writes one 64-bit word per cycle; end of instruction
//   writes one word of the live set per cycle; is-live reads the saved word,
//   then tests its bit; free run reads each word, then scans one byte per cycle.
// Throughput: one item at a time; req_ready is high only when the sequencer idles.
// Reset: async, clears the live set, slot valid bits, scalar max and control;
//   the saved-set memory is not cleared, slot valid bits guard it.
module register_liveness_free_run_finder_core
	import rlf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [2:0]        func,
	input  logic [7:0]        slot,
	input  logic              is_vector,
	input  logic [8:0]        reg_base,
	input  logic [9:0]        reg_count,
	input  logic signed [9:0] operand_code,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              found,
	output logic [8:0]        reg_index
);

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	state_t                 state_q;
	func_t                  op_q;
	logic [WORD_BITS-1:0]   live_now_q [WORDS];
	logic [NUM_SLOTS-1:0]   slot_valid_q;
	logic [6:0]             max_scalar_q;

	// per-item working registers
	logic [7:0]             slot_q;
	logic [8:0]             base_q;
	logic [9:0]             count_q;
	logic [POS_W-1:0]       end_q;
	logic                   set_q;      // src range sets, dst range clears
	logic                   sv_q;       // queried slot holds a saved set
	logic [WORD_AW-1:0]     word_q;
	logic [STEPS_AW-1:0]    byte_q;
	logic [9:0]             run_q;      // free bits in a row ending at scan point
	logic                   res_found_q;
	logic [8:0]             res_idx_q;

	// saved live sets, one 64-bit word per entry, registered read
	logic [WORD_BITS-1:0]   mem [MEM_DEPTH];
	logic [WORD_BITS-1:0]   rdata_q;
	logic [MEM_AW-1:0]      mem_addr;
	logic                   mem_we;

	// output register
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [8:0]             out_idx_q;

	logic                   accept;
	logic                   out_load;
	func_t                  fn;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign fn        = func_t'(func);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp_ready);

	assign rsp_valid = out_valid_q;
	assign found     = out_found_q;
	assign reg_index = out_idx_q;

	assign mem_addr  = {SLOT_AW'(slot_q), word_q};
	assign mem_we    = (state_q == ST_SAVE);

	// ------------------------------------------------------------------
	// scalar search, evaluated at accept from the running maximum
	// ------------------------------------------------------------------
	logic [9:0] sc_start;
	logic [9:0] sc_b;
	logic       sc_found;
	logic [8:0] sc_idx;

	always_comb begin
		sc_start = 10'(max_scalar_q) + 10'd1;
		sc_b     = (10'(reg_base) > sc_start) ? 10'(reg_base) : sc_start;
		if (fn == FN_PAIR) begin
			sc_b     = sc_b + 10'(sc_b[0]);
			sc_found = (sc_b + 10'd1) < 10'(SCALAR_LIMIT);
		end else begin
			sc_found = sc_b < 10'(SCALAR_LIMIT);
		end
		sc_idx = sc_found ? sc_b[8:0] : 9'd0;
	end

	// scalar high-water mark from the operand code of src and dst items (pattern read unsigned)
	logic [9:0] code_u;
	logic       code_raise;
	assign code_u     = $unsigned(operand_code);
	assign code_raise = (code_u <= 10'(SCALAR_LAST)) && (code_u > 10'(max_scalar_q));

	// ------------------------------------------------------------------
	// range marking mask for the current live word
	// ------------------------------------------------------------------
	logic [WORD_BITS-1:0] mark_mask;
	logic [WORD_BITS-1:0] mark_word;
	logic                 mark_last;

	always_comb begin
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			p = POS_W'({word_q, BIT_AW'(i)});
			mark_mask[i] = (p >= POS_W'(base_q)) && (p < end_q);
		end
		mark_word = set_q ? (live_now_q[word_q] | mark_mask)
		                  : (live_now_q[word_q] & ~mark_mask);
		mark_last = (word_q == WORD_AW'(WORDS - 1)) ||
		            (POS_W'({word_q, BIT_AW'(0)}) + POS_W'(WORD_BITS) >= end_q);
	end

	// ------------------------------------------------------------------
	// free-run scan step: one byte of the saved word per cycle
	// ------------------------------------------------------------------
	logic [9:0] step_run;
	logic       step_hit;
	logic [8:0] step_idx;
	logic       scan_last;

	always_comb begin
		logic [POS_W-1:0] p;
		logic             busy;
		logic             free_b;
		logic [POS_W-1:0] hi;
		p        = '0;
		busy     = 1'b0;
		free_b   = 1'b0;
		hi       = '0;
		step_run = run_q;
		step_hit = 1'b0;
		step_idx = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			p      = POS_W'({word_q, byte_q, STEP_AW'(i)});
			busy   = sv_q && rdata_q[{byte_q, STEP_AW'(i)}];
			free_b = !busy && (p >= POS_W'(base_q));
			step_run = free_b ? (step_run + 10'd1) : 10'd0;
			if (!step_hit && (step_run == count_q)) begin
				step_hit = 1'b1;
				hi       = p - POS_W'(count_q) + POS_W'(1);
				step_idx = hi[8:0];
			end
		end
		scan_last = (word_q == WORD_AW'(WORDS - 1)) && (byte_q == STEPS_AW'(STEP_BITS - 1));
	end

	// ------------------------------------------------------------------
	// saved-set memory
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= live_now_q[word_q];
		end
		rdata_q <= mem[mem_addr];
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= FN_CLEAR;
			slot_valid_q <= '0;
			max_scalar_q <= '0;
			for (int w = 0; w < WORDS; w++) begin
				live_now_q[w] <= '0;
			end
			slot_q       <= '0;
			base_q       <= '0;
			count_q      <= '0;
			end_q        <= '0;
			set_q        <= 1'b0;
			sv_q         <= 1'b0;
			word_q       <= '0;
			byte_q       <= '0;
			run_q        <= '0;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q        <= fn;
						slot_q      <= slot;
						base_q      <= reg_base;
						count_q     <= reg_count;
						end_q       <= POS_W'(reg_base) + POS_W'(reg_count);
						set_q       <= (fn == FN_SRC);
						sv_q        <= (32'(slot) < NUM_SLOTS) && slot_valid_q[SLOT_AW'(slot)];
						// end of instruction saves the whole set from word 0
						word_q      <= (fn == FN_END) ? WORD_AW'(0)
						                              : WORD_AW'(reg_base >> BIT_AW);
						byte_q      <= '0;
						run_q       <= '0;
						// scalar queries resolve here, everything else starts empty
						res_found_q <= ((fn == FN_SCALAR) || (fn == FN_PAIR)) && sc_found;
						res_idx_q   <= ((fn == FN_SCALAR) || (fn == FN_PAIR)) ? sc_idx : 9'd0;
						case (fn)
							FN_CLEAR: begin
								slot_valid_q <= '0;
								max_scalar_q <= '0;
								for (int w = 0; w < WORDS; w++) begin
									live_now_q[w] <= '0;
								end
								state_q <= ST_DONE;
							end
							FN_DST, FN_SRC: begin
								if (code_raise) begin
									max_scalar_q <= code_u[6:0];
								end
								state_q <= (is_vector && (32'(reg_base) < NUM_VREGS)) ?
								           ST_MARK : ST_DONE;
							end
							FN_END: begin
								if (32'(slot) < NUM_SLOTS) begin
									slot_valid_q[SLOT_AW'(slot)] <= 1'b1;
									state_q <= ST_SAVE;
								end else begin
									state_q <= ST_DONE;
								end
							end
							FN_FREERUN: begin
								state_q <= ((reg_count != '0) && (32'(reg_base) < NUM_VREGS)) ?
								           ST_RD : ST_DONE;
							end
							FN_ISLIVE: begin
								state_q <= (32'(reg_base) < NUM_VREGS) ? ST_RD : ST_DONE;
							end
							FN_SCALAR, FN_PAIR: begin
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_MARK: begin
					live_now_q[word_q] <= mark_word;
					word_q             <= word_q + WORD_AW'(1);
					if (mark_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_SAVE: begin
					word_q <= word_q + WORD_AW'(1);
					if (word_q == WORD_AW'(WORDS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_RD: begin
					// read data lands in rdata_q at this edge
					state_q <= (op_q == FN_ISLIVE) ? ST_LIVE : ST_SCAN;
				end
				ST_LIVE: begin
					res_found_q <= sv_q && rdata_q[base_q[BIT_AW-1:0]];
					state_q     <= ST_DONE;
				end
				ST_SCAN: begin
					run_q  <= step_run;
					byte_q <= byte_q + STEPS_AW'(1);
					if (step_hit) begin
						res_found_q <= 1'b1;
						res_idx_q   <= step_idx;
						state_q     <= ST_DONE;
					end else if (scan_last) begin
						state_q <= ST_DONE;
					end else if (byte_q == STEPS_AW'(STEP_BITS - 1)) begin
						word_q  <= word_q + WORD_AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// output register: holds one result beat until taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_found_q <= res_found_q;
				out_idx_q   <= res_idx_q;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_scan_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("free-run scan running with zero length");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (fn == FN_CLEAR)) |=> ((max_scalar_q == '0) && (slot_valid_q == '0)))
		else $error("clear beat did not reset block state");

	a_scalar_bound: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (max_scalar_q <= 7'(SCALAR_LAST)))
		else $error("scalar maximum beyond last scalar register");

	a_fail_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !found) |-> (reg_index == '0))
		else $error("failed result carries nonzero index");

endmodule

// ----- tb/rlf_liveness_checker.sv -----
// ----------------------------------------------------------------------------
// rlf_liveness_checker
// Watches the request and response channels of the liveness core, keeps its
// own copy of the live set, saved slot sets and scalar maximum, and compares
// every response beat with the oldest predicted answer.
// ----------------------------------------------------------------------------
module rlf_liveness_checker
	import rlf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic [2:0]        func,
	input  logic [7:0]        slot,
	input  logic              is_vector,
	input  logic [8:0]        reg_base,
	input  logic [9:0]        reg_count,
	input  logic signed [9:0] operand_code,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              found,
	input  logic [8:0]        reg_index,
	output int                fail_count,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic       fnd;
		logic [8:0] idx;
	} answer_t;

	logic [NUM_VREGS-1:0] live_set;
	logic [NUM_VREGS-1:0] saved_tbl [NUM_SLOTS];
	logic                 slot_saved [NUM_SLOTS];
	logic [6:0]           max_scalar;
	answer_t              answer_q [$];

	// first-fit: on a live bit, restart the window just past it
	function automatic answer_t first_free_run(logic [NUM_VREGS-1:0] set, int start, int len);
		answer_t a;
		int      b;
		bit      hit;
		a = '0;
		if (len == 0)
			return a;
		b = start;
		while (b + len <= NUM_VREGS) begin
			hit = 1'b0;
			for (int i = 0; i < len; i++) begin
				if (set[b + i]) begin
					hit = 1'b1;
					b = b + i;
					break;
				end
			end
			if (!hit) begin
				a.fnd = 1'b1;
				a.idx = b[8:0];
				return a;
			end
			b++;
		end
		return a;
	endfunction

	// applies one request beat to the shadow state, returns the expected answer
	function automatic answer_t predict_answer(func_t fn, logic [7:0] s, logic v,
			logic [8:0] b, logic [9:0] c, logic [9:0] code);
		answer_t              a;
		logic [NUM_VREGS-1:0] view;
		int                   start;
		a = '0;
		view = slot_saved[s] ? saved_tbl[s] : '0;
		case (fn)
			FN_CLEAR: begin
				live_set = '0;
				foreach (slot_saved[i])
					slot_saved[i] = 1'b0;
				max_scalar = '0;
			end
			FN_DST, FN_SRC: begin
				if (v)
					for (int i = 0; i < c && b + i < NUM_VREGS; i++)
						live_set[b + i] = (fn == FN_SRC);
				// negative codes are large as raw bit patterns
				if (code <= SCALAR_LAST && code > max_scalar)
					max_scalar = code[6:0];
			end
			FN_END: begin
				saved_tbl[s] = live_set;
				slot_saved[s] = 1'b1;
			end
			FN_FREERUN: a = first_free_run(view, b, c);
			FN_ISLIVE:  a.fnd = view[b];
			FN_SCALAR, FN_PAIR: begin
				start = max_scalar + 1;
				if (b > start)
					start = b;
				if (fn == FN_PAIR && start[0])
					start++;
				if ((fn == FN_PAIR) ? (start + 1 < SCALAR_LIMIT) : (start < SCALAR_LIMIT)) begin
					a.fnd = 1'b1;
					a.idx = start[8:0];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic flag_field(string name, logic [8:0] want_v, logic [8:0] got_v);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			live_set = '0;
			foreach (slot_saved[i])
				slot_saved[i] = 1'b0;
			max_scalar = '0;
			answer_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// retire first: a response never belongs to a request taken on the same edge
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					fail_count++;
					$error("response beat with nothing pending: found=%0d reg_index=%0d",
						found, reg_index);
				end else begin
					want = answer_q.pop_front();
					if (found !== want.fnd)
						flag_field("found", want.fnd, found);
					if (reg_index !== want.idx)
						flag_field("reg_index", want.idx, reg_index);
				end
			end
			if (req_valid && req_ready)
				answer_q = {answer_q, predict_answer(func_t'(func), slot, is_vector,
					reg_base, reg_count, operand_code)};
			outstanding = answer_q.size();
		end
	end

endmodule

// ----- tb/tb_register_liveness_free_run_finder_core.sv -----
// ----------------------------------------------------------------------------
// tb_register_liveness_free_run_finder_core
// Drives operand, end-of-instruction and query beats into the liveness core:
// a directed opening on edge cases, then random basic blocks fed last
// instruction first, each followed by queries. Both channels idle at random.
// Checking is done by rlf_liveness_checker beside the core.
// ----------------------------------------------------------------------------
module tb_register_liveness_free_run_finder_core
	import rlf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET  = 800;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// covers the longest free-run scan, plus margin for late stray beats
	localparam int DRAIN_CYCLES = 100;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              req_valid    = 1'b0;
	logic              req_ready;
	func_t             func         = FN_CLEAR;
	logic [7:0]        slot         = '0;
	logic              is_vector    = 1'b0;
	logic [8:0]        reg_base     = '0;
	logic [9:0]        reg_count    = '0;
	logic signed [9:0] operand_code = '0;
	logic              rsp_valid;
	logic              rsp_ready    = 1'b0;
	logic              found;
	logic [8:0]        reg_index;

	int fail_count;
	int outstanding;
	int cycle_cnt = 0;

	// steady: both sides run without idling for the current block
	bit steady   = 1'b0;
	int rsp_hold = 0;

	int items    = 0;
	int directed = 0;
	int blocks   = 0;
	int sent_by_fn [8];

	always #6 clk = ~clk;

	register_liveness_free_run_finder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.slot         (slot),
		.is_vector    (is_vector),
		.reg_base     (reg_base),
		.reg_count    (reg_count),
		.operand_code (operand_code),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.found        (found),
		.reg_index    (reg_index)
	);

	rlf_liveness_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.slot         (slot),
		.is_vector    (is_vector),
		.reg_base     (reg_base),
		.reg_count    (reg_count),
		.operand_code (operand_code),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.found        (found),
		.reg_index    (reg_index),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// idle length: half none, most of the rest short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// range length / run length: mostly short, a few spanning the whole file
	function automatic logic [9:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 10'd0;
		if (r < 75)
			return 10'($urandom_range(1, 16));
		if (r < 92)
			return 10'($urandom_range(17, 128));
		return 10'($urandom_range(129, 512));
	endfunction

	// operand encodings: low scalars common, high scalars rare so the scalar
	// maximum does not pin at the top in every block
	function automatic logic signed [9:0] rand_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 10'($urandom_range(0, 31));
		if (r < 50)
			return 10'($urandom_range(32, SCALAR_LAST));
		if (r < 85)
			return 10'($urandom_range(SCALAR_LIMIT, 511));
		return -10'sd1;
	endfunction

	// one request beat; valid is only lowered when a gap precedes this beat, so
	// back-to-back beats keep valid high across the accepting edge
	task automatic issue(func_t f, logic [7:0] s, logic v, logic [8:0] b, logic [9:0] c,
			logic signed [9:0] oc);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		func         <= f;
		slot         <= s;
		is_vector    <= v;
		reg_base     <= b;
		reg_count    <= c;
		operand_code <= oc;
		do
			@(posedge clk);
		while (!req_ready);
		sent_by_fn[f]++;
		items++;
	endtask

	// one query against the block just built (slots s0 .. s0+n-1) or elsewhere
	task automatic ask(logic [7:0] s0, int n);
		int         r;
		logic [7:0] s;
		logic [8:0] b;
		logic [9:0] c;
		r = $urandom_range(0, 99);
		s = ($urandom_range(0, 4) != 0) ? 8'(s0 + $urandom_range(0, n - 1)) : 8'($urandom);
		if (r < 40) begin
			b = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 63)) : 9'($urandom);
			r = $urandom_range(0, 99);
			if (r < 5)
				c = 10'd0;
			else if (r < 65)
				c = 10'($urandom_range(1, 8));
			else if (r < 90)
				c = 10'($urandom_range(9, 64));
			else
				c = 10'($urandom_range(65, 512));
			issue(FN_FREERUN, s, 1'($urandom), b, c, rand_code());
		end else if (r < 70) begin
			issue(FN_ISLIVE, s, 1'($urandom), 9'($urandom), rand_count(), rand_code());
		end else begin
			b = ($urandom_range(0, 9) < 6) ? 9'($urandom_range(0, 110)) : 9'($urandom);
			issue((r < 85) ? FN_SCALAR : FN_PAIR, s, 1'($urandom), b, rand_count(),
				rand_code());
		end
	endtask

	// one basic block, last instruction first, then a handful of queries
	task automatic run_block();
		int         n_instr;
		int         n_ops;
		logic [7:0] s0;
		steady <= ($urandom_range(0, 4) == 0);
		blocks++;
		// now and then keep the previous block's saved slots alive
		if ($urandom_range(0, 9) != 0)
			issue(FN_CLEAR, 8'($urandom), 1'($urandom), 9'($urandom), rand_count(),
				rand_code());
		n_instr = $urandom_range(1, 12);
		s0 = 8'($urandom_range(0, NUM_SLOTS - n_instr));
		for (int k = n_instr - 1; k >= 0; k--) begin
			n_ops = $urandom_range(0, 4);
			repeat (n_ops) begin
				if ($urandom_range(0, 99) < 8)
					// noise: anything at all, including a stray clear or query
					issue(func_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
						9'($urandom), 10'($urandom_range(0, 512)), rand_code());
				else
					issue(($urandom_range(0, 1) != 0) ? FN_SRC : FN_DST, 8'($urandom),
						($urandom_range(0, 3) != 0),
						($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 127)) : 9'($urandom),
						rand_count(), rand_code());
			end
			issue(FN_END, 8'(s0 + k), 1'($urandom), 9'($urandom), rand_count(), rand_code());
		end
		repeat ($urandom_range(2, 8))
			ask(s0, n_instr);
	endtask

	// response side backpressure, held off in steady stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_hold > 0) begin
				rsp_hold  <= rsp_hold - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 30)
					rsp_hold <= idle_len();
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$error("watchdog expired after %0d cycles, %0d answers still pending",
			cycle_cnt, outstanding);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed opening ---
		// nothing saved yet: reads as all free
		issue(FN_ISLIVE,   8'd0,   1'b0, 9'd0,   10'd1,   10'sd0);
		issue(FN_FREERUN,  8'd5,   1'b0, 9'd0,   10'd512, 10'sd0);
		// zero run length always fails
		issue(FN_FREERUN,  8'd5,   1'b1, 9'd3,   10'd0,   10'sd0);
		// scalar max still zero: register 0 is never handed out
		issue(FN_SCALAR,   8'd0,   1'b0, 9'd0,   10'd0,   10'sd0);
		issue(FN_PAIR,     8'd0,   1'b0, 9'd0,   10'd0,   10'sd0);
		// range running off the top of the file, negative code ignored
		issue(FN_SRC,      8'd0,   1'b1, 9'd500, 10'd512, -10'sd1);
		// dst punches a hole; code at the scalar ceiling
		issue(FN_DST,      8'd0,   1'b1, 9'd504, 10'd2,   10'sd105);
		issue(FN_SRC,      8'd0,   1'b1, 9'd0,   10'd1,   10'sd511);
		// scalar operand: range fields ignored
		issue(FN_SRC,      8'd0,   1'b0, 9'd100, 10'd50,  10'sd7);
		issue(FN_END,      8'd255, 1'b0, 9'd0,   10'd0,   10'sd0);
		issue(FN_SRC,      8'd0,   1'b1, 9'd64,  10'd64,  10'sd0);
		issue(FN_END,      8'd254, 1'b0, 9'd0,   10'd0,   10'sd0);
		issue(FN_ISLIVE,   8'd255, 1'b0, 9'd511, 10'd0,   10'sd0);
		issue(FN_ISLIVE,   8'd255, 1'b0, 9'd504, 10'd0,   10'sd0);
		// live bit 0 pushes the run to 1
		issue(FN_FREERUN,  8'd255, 1'b0, 9'd0,   10'd8,   10'sd0);
		// skips the whole live word 64..127
		issue(FN_FREERUN,  8'd254, 1'b0, 9'd60,  10'd10,  10'sd0);
		// runs off the end of the file
		issue(FN_FREERUN,  8'd255, 1'b0, 9'd505, 10'd7,   10'sd0);
		// scalar max is 105: no room left
		issue(FN_SCALAR,   8'd0,   1'b0, 9'd0,   10'd0,   10'sd0);
		issue(FN_PAIR,     8'd0,   1'b0, 9'd0,   10'd0,   10'sd0);
		issue(FN_CLEAR,    8'd0,   1'b0, 9'd0,   10'd0,   10'sd0);
		// after clear: search start from reg_base, pair rounds up to even
		issue(FN_SCALAR,   8'd0,   1'b0, 9'd104, 10'd0,   10'sd0);
		issue(FN_PAIR,     8'd0,   1'b0, 9'd103, 10'd0,   10'sd0);
		issue(FN_PAIR,     8'd0,   1'b0, 9'd105, 10'd0,   10'sd0);
		// clear invalidated the slot
		issue(FN_ISLIVE,   8'd255, 1'b0, 9'd511, 10'd0,   10'sd0);
		issue(FN_SCALAR,   8'd0,   1'b0, 9'd511, 10'd0,   10'sd0);
		directed = items;

		// --- random blocks ---
		while (items < directed + ITEM_TARGET)
			run_block();
		req_valid <= 1'b0;
		steady    <= 1'b0;

		// one edge so the last beat is in the checker's queue, then drain
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d beats (%0d directed) across %0d blocks: %0d dst, %0d src, %0d end, %0d clear.",
			items, directed, blocks, sent_by_fn[FN_DST], sent_by_fn[FN_SRC],
			sent_by_fn[FN_END], sent_by_fn[FN_CLEAR]);
		$display("Queries: %0d free-run, %0d is-live, %0d free scalar, %0d scalar pair.",
			sent_by_fn[FN_FREERUN], sent_by_fn[FN_ISLIVE], sent_by_fn[FN_SCALAR],
			sent_by_fn[FN_PAIR]);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
